[design/fpbq_pkg.sv]
package fpbq_pkg;

	localparam int SCALE_SHIFT_DEF = 16;
	localparam int COEF_SHIFT_DEF  = 24;

	localparam int SAMPLE_W = 12;
	localparam int COEF_W   = 27;
	localparam int HIST_W   = 32;
	localparam int OUT_W    = 17;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [SAMPLE_W-1:0]      OFFSET_RESET = 12'd1500;
	localparam logic signed [OUT_W-1:0]  OUT_LOW      = -17'sd32768;
	localparam logic signed [OUT_W-1:0]  OUT_HIGH     = 17'sd36863;

	typedef enum logic [2:0] {
		REG_B0     = 3'd0,
		REG_B1     = 3'd1,
		REG_B2     = 3'd2,
		REG_A1     = 3'd3,
		REG_A2     = 3'd4,
		REG_OFFSET = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	typedef struct packed {
		logic step;    // item moves from input register to result register
		logic primed;  // history holds real samples
	} dp_ctrl_t;

	// clamp to the 32-bit signed range
	function automatic logic signed [HIST_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			return hi[HIST_W-1:0];
		end else if (v < lo) begin
			return lo[HIST_W-1:0];
		end
		return v[HIST_W-1:0];
	endfunction

endpackage

[design/fpbq_datapath.sv]
module fpbq_datapath #(
	parameter int SCALE_SHIFT = fpbq_pkg::SCALE_SHIFT_DEF,
	parameter int COEF_SHIFT  = fpbq_pkg::COEF_SHIFT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fpbq_pkg::dp_ctrl_t                    ctrl,
	input  logic [fpbq_pkg::SAMPLE_W-1:0]         sample,
	input  logic [fpbq_pkg::SAMPLE_W-1:0]         offset,
	input  fpbq_pkg::coef_set_t                   coefs,
	output logic signed [fpbq_pkg::OUT_W-1:0]     result
);
	import fpbq_pkg::*;

	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int XW     = DIFF_W + SCALE_SHIFT;
	localparam int PROD_W = HIST_W + COEF_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RND_W  = HIST_W + 1;
	localparam int R_W    = HIST_W + 2;

	logic signed [HIST_W-1:0] ih0_q, ih1_q, oh0_q, oh1_q;

	logic signed [DIFF_W-1:0] diff;
	logic signed [XW-1:0]     xs_wide;
	logic signed [HIST_W-1:0] xs, x1, x2, y1, y2, y0;
	logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]  acc, acc_sh;
	logic signed [RND_W-1:0]  rnd;
	logic signed [R_W-1:0]    off_ext, r;

	always_comb begin
		diff    = $signed({1'b0, sample}) - $signed({1'b0, offset});
		xs_wide = {diff, {SCALE_SHIFT{1'b0}}};
		xs      = sat32({{(64-XW){xs_wide[XW-1]}}, xs_wide});

		// unprimed history reads as the current sample
		x1 = ctrl.primed ? ih0_q : xs;
		x2 = ctrl.primed ? ih1_q : xs;
		y1 = ctrl.primed ? oh0_q : xs;
		y2 = ctrl.primed ? oh1_q : xs;

		p_b0 = xs * coefs.b0;
		p_b1 = x1 * coefs.b1;
		p_b2 = x2 * coefs.b2;
		p_a1 = y1 * coefs.a1;
		p_a2 = y2 * coefs.a2;

		acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);
		acc_sh = acc >>> COEF_SHIFT;
		y0 = sat32({{(64-ACC_W){acc_sh[ACC_W-1]}}, acc_sh});

		// round half up, then restore bias
		rnd     = ($signed({y0[HIST_W-1], y0}) + (RND_W'(1) <<< (SCALE_SHIFT - 1)))
			>>> SCALE_SHIFT;
		off_ext = $signed({{(R_W-SAMPLE_W){1'b0}}, offset});
		r       = {rnd[RND_W-1], rnd} + off_ext;

		if (r > R_W'(OUT_HIGH)) begin
			result = OUT_HIGH;
		end else if (r < R_W'(OUT_LOW)) begin
			result = OUT_LOW;
		end else begin
			result = r[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ih0_q <= '0;
			ih1_q <= '0;
			oh0_q <= '0;
			oh1_q <= '0;
		end else if (ctrl.step) begin
			ih1_q <= x1;
			ih0_q <= xs;
			oh1_q <= y1;
			oh0_q <= y0;
		end
	end

endmodule

[design/fixed_point_biquad_lowpass_top.sv]
// channel   signals                         dir   moves
// input     in_valid, in_stall, sample_in   in    one raw 12-bit sample per item
// output    out_valid, out_stall, sample_out out  one filtered 17-bit sample per item
// config    psel/penable/pwrite/paddr/...   in    coefficients and bias, 4-byte stride
//
// One item per cycle while out_stall is low; an accepted sample is held in the input register,
// then its result in the result register, where out_valid marks it for the sink.
// The recursion closes between the input register and the result register: five 32x27 multiplies,
// the 62-bit sum, shift, saturate and round all sit between those two registers.
// Reset (arst_n low) empties both registers, loads bias 1500 and zero coefficients.
// out_stall holds the result register; in_stall rises only when both registers are full.
// Any write to a listed register clears primed: the next item seeds all history.
module fixed_point_biquad_lowpass_top #(
	parameter int SCALE_SHIFT = fpbq_pkg::SCALE_SHIFT_DEF,
	parameter int COEF_SHIFT  = fpbq_pkg::COEF_SHIFT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fpbq_pkg::SAMPLE_W-1:0]       sample_in,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fpbq_pkg::OUT_W-1:0]   sample_out,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fpbq_pkg::ADDR_W-1:0]         paddr,
	input  logic [fpbq_pkg::DATA_W-1:0]         pwdata,
	output logic [fpbq_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import fpbq_pkg::*;

	// configuration
	coef_set_t             coefs_q;
	logic [SAMPLE_W-1:0]   offset_q;
	logic                  primed_q;
	logic                  cfg_wr;
	logic                  cfg_hit;
	reg_idx_t              cfg_idx;

	// pipeline
	logic                  valid_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic                  valid_s2;
	logic signed [OUT_W-1:0] result_s2;
	logic                  advance;
	logic                  accept;
	dp_ctrl_t              dp_ctrl;
	logic signed [OUT_W-1:0] dp_result;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_OFFSET: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q  <= '0;
			offset_q <= OFFSET_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_B0:     coefs_q.b0 <= pwdata[COEF_W-1:0];
				REG_B1:     coefs_q.b1 <= pwdata[COEF_W-1:0];
				REG_B2:     coefs_q.b2 <= pwdata[COEF_W-1:0];
				REG_A1:     coefs_q.a1 <= pwdata[COEF_W-1:0];
				REG_A2:     coefs_q.a2 <= pwdata[COEF_W-1:0];
				REG_OFFSET: offset_q   <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// readback, coefficients sign-extended
	always_comb begin
		unique case (cfg_idx)
			REG_B0:     prdata = DATA_W'(coefs_q.b0);
			REG_B1:     prdata = DATA_W'(coefs_q.b1);
			REG_B2:     prdata = DATA_W'(coefs_q.b2);
			REG_A1:     prdata = DATA_W'(coefs_q.a1);
			REG_A2:     prdata = DATA_W'(coefs_q.a2);
			REG_OFFSET: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, offset_q};
			default:    prdata = '0;
		endcase
	end

	// primed: cleared by a write to a listed register, set by the first item through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (cfg_wr && cfg_hit) begin
			primed_q <= 1'b0;
		end else if (advance) begin
			primed_q <= 1'b1;
		end
	end

	// handshake: s1 moves when the result register is empty or being drained
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & valid_s2 & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
		end
		if (advance) begin
			result_s2 <= dp_result;
		end
	end

	assign dp_ctrl.step   = advance;
	assign dp_ctrl.primed = primed_q;

	fpbq_datapath #(
		.SCALE_SHIFT(SCALE_SHIFT),
		.COEF_SHIFT (COEF_SHIFT)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (dp_ctrl),
		.sample(sample_s1),
		.offset(offset_q),
		.coefs (coefs_q),
		.result(dp_result)
	);

	assign out_valid  = valid_s2;
	assign sample_out = result_s2;

	// a full pipe facing a stalled sink must push back
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> in_stall)
		else $error("input not stalled with both stages full");

	// an item leaving s1 always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register empty after advance");

	// a listed register write always forces a re-prime
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg_hit) |=> !primed_q)
		else $error("primed survived a config write");

	// stall toward the source only when something is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

endmodule
